[sv/atrp_pkg.sv]
`default_nettype none

package atrp_pkg;

  // field and datapath widths
  localparam int AXIS_W   = 16;
  localparam int SUM_W    = 17;
  localparam int SQ_W     = 33;
  localparam int RAD_W    = 34;
  localparam int FRAC_SH  = 16;
  localparam int REM_W    = RAD_W + FRAC_SH;
  localparam int ROOT_STEPS = REM_W / 2;
  localparam int ROOT_W   = ROOT_STEPS;
  localparam int TRIAL_W  = REM_W + 1;
  localparam int NUM_SH   = 8;
  localparam int CX_W     = 28;
  localparam int ACC_W    = 25;
  localparam int ATAN_W   = 22;
  localparam int ATAN_IDX_W = 5;
  localparam int MAX_STEPS = 24;
  localparam int RND_SH   = 8;
  localparam int ANGLE_W  = 16;
  localparam int FRONT_STAGES = 3;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd23040;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -16'sd23040;

  // register word indexes (byte address bits [3:2])
  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;

  localparam logic signed [AXIS_W-1:0] OFFSET_X_RST = -16'sd164;
  localparam logic signed [AXIS_W-1:0] OFFSET_Y_RST = -16'sd41;
  localparam logic signed [AXIS_W-1:0] OFFSET_Z_RST = 16'sd1065;

  // side flags carried along the cordic stages
  typedef struct packed {
    logic zden;
    logic pos;
    logic neg;
  } atrp_flags_t;

  // atan(2^-i) in degrees times 2^16, rounded
  function automatic logic [ATAN_W-1:0] atan_deg16(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/atrp_tilt.sv]
`default_nettype none

module atrp_tilt #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [atrp_pkg::RAD_W-1:0]           in_rad,
  input  logic signed [atrp_pkg::SUM_W-1:0]    in_num,
  output logic                                 out_valid,
  output logic signed [atrp_pkg::ANGLE_W-1:0]  out_angle
);
  import atrp_pkg::*;

  localparam int NST = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int Q_W = ACC_W + 1 - RND_SH;

  // integer square root, one root bit per stage
  logic                     sq_v_r    [ROOT_STEPS];
  logic [REM_W-1:0]         sq_rem_r  [ROOT_STEPS];
  logic [TRIAL_W-1:0]       sq_root_r [ROOT_STEPS];
  logic signed [SUM_W-1:0]  sq_num_r  [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
    localparam logic [TRIAL_W-1:0] BIT_K = TRIAL_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic                    vld_prev;
    logic [REM_W-1:0]        rem_prev;
    logic [TRIAL_W-1:0]      root_prev;
    logic [TRIAL_W-1:0]      trial;
    logic signed [SUM_W-1:0] num_prev;

    if (k == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign rem_prev  = {in_rad, {FRAC_SH{1'b0}}};
      assign root_prev = '0;
      assign num_prev  = in_num;
    end else begin : g_next
      assign vld_prev  = sq_v_r[k-1];
      assign rem_prev  = sq_rem_r[k-1];
      assign root_prev = sq_root_r[k-1];
      assign num_prev  = sq_num_r[k-1];
    end

    assign trial = root_prev + BIT_K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else begin
        sq_v_r[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      sq_num_r[k] <= num_prev;
      if ({1'b0, rem_prev} >= trial) begin
        sq_rem_r[k]  <= rem_prev - trial[REM_W-1:0];
        sq_root_r[k] <= (root_prev >> 1) + BIT_K;
      end else begin
        sq_rem_r[k]  <= rem_prev;
        sq_root_r[k] <= root_prev >> 1;
      end
    end
  end

  logic [ROOT_W-1:0]       root;
  logic signed [SUM_W-1:0] num_s;
  assign root  = sq_root_r[ROOT_STEPS-1][ROOT_W-1:0];
  assign num_s = sq_num_r[ROOT_STEPS-1];

  // cordic vectoring, one micro-rotation per stage
  logic                     cd_v_r    [NST];
  logic signed [CX_W-1:0]   cd_x_r    [NST];
  logic signed [CX_W-1:0]   cd_y_r    [NST];
  logic signed [ACC_W-1:0]  cd_acc_r  [NST];
  atrp_flags_t              cd_flag_r [NST];

  for (genvar j = 0; j < NST; j++) begin : g_cordic
    logic                    vld_prev;
    logic signed [CX_W-1:0]  x_prev;
    logic signed [CX_W-1:0]  y_prev;
    logic signed [ACC_W-1:0] acc_prev;
    atrp_flags_t             flag_prev;
    logic signed [CX_W-1:0]  sx;
    logic signed [CX_W-1:0]  sy;
    logic signed [ACC_W-1:0] at;

    if (j == 0) begin : g_first
      assign vld_prev  = sq_v_r[ROOT_STEPS-1];
      assign x_prev    = $signed({{(CX_W-ROOT_W){1'b0}}, root});
      assign y_prev    = $signed({{(CX_W-SUM_W-NUM_SH){num_s[SUM_W-1]}}, num_s,
                                  {NUM_SH{1'b0}}});
      assign acc_prev  = '0;
      assign flag_prev = '{zden: (root == '0),
                           pos:  (!num_s[SUM_W-1] && (num_s != '0)),
                           neg:  num_s[SUM_W-1]};
    end else begin : g_next
      assign vld_prev  = cd_v_r[j-1];
      assign x_prev    = cd_x_r[j-1];
      assign y_prev    = cd_y_r[j-1];
      assign acc_prev  = cd_acc_r[j-1];
      assign flag_prev = cd_flag_r[j-1];
    end

    assign sx = x_prev >>> j;
    assign sy = y_prev >>> j;
    assign at = $signed({{(ACC_W-ATAN_W){1'b0}}, atan_deg16(ATAN_IDX_W'(j))});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_v_r[j] <= 1'b0;
      end else begin
        cd_v_r[j] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      cd_flag_r[j] <= flag_prev;
      if (!y_prev[CX_W-1]) begin
        cd_x_r[j]   <= x_prev + sy;
        cd_y_r[j]   <= y_prev - sx;
        cd_acc_r[j] <= acc_prev + at;
      end else begin
        cd_x_r[j]   <= x_prev - sy;
        cd_y_r[j]   <= y_prev + sx;
        cd_acc_r[j] <= acc_prev - at;
      end
    end
  end

  // round half up to 8 fraction bits, saturate, zero denominator override
  logic signed [ACC_W:0]      acc_rnd;
  logic signed [Q_W-1:0]      q;
  logic signed [ANGLE_W-1:0]  angle_nxt;
  atrp_flags_t                fl;
  logic                       out_valid_r;
  logic signed [ANGLE_W-1:0]  out_angle_r;

  assign fl      = cd_flag_r[NST-1];
  assign acc_rnd = {cd_acc_r[NST-1][ACC_W-1], cd_acc_r[NST-1]} + (ACC_W+1)'(128);
  assign q       = acc_rnd[ACC_W:RND_SH];

  always_comb begin
    if (fl.zden) begin
      if (fl.pos) begin
        angle_nxt = ANGLE_MAX;
      end else if (fl.neg) begin
        angle_nxt = ANGLE_MIN;
      end else begin
        angle_nxt = '0;
      end
    end else if (q > ANGLE_MAX) begin
      angle_nxt = ANGLE_MAX;
    end else if (q < ANGLE_MIN) begin
      angle_nxt = ANGLE_MIN;
    end else begin
      angle_nxt = q[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cd_v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r <= angle_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule

`default_nettype wire

[sv/accel_tilt_roll_pitch_top.sv]
// accelerometer tilt: roll and pitch from one three-axis sample
// input channel: drive in_accel_x/y/z and pulse start; the word is taken at
//   a clock edge with start high and busy low. busy is always low, so a new
//   word can be taken at every edge.
// output channel: out_valid is high for exactly one cycle with
//   out_roll_angle and out_pitch_angle (degrees times 256, signed). the
//   receiver cannot stall, so it must take every word in that cycle.
// throughput: one word per clock.
// the pipeline is offset add, square, sum of squares, a 25-stage integer
//   square root (one root bit per stage) and a CORDIC_STEPS-stage vectoring
//   cordic (one micro-rotation per stage), plus an output round/saturate
//   stage; the square root depth and cordic depth set the latency.
// configuration: apb-style port, offset_x at 0x0, offset_y at 0x4,
//   offset_z at 0x8; write only while no words are in flight.
// reset (rst_n low, synchronous): valid bits along the pipe clear, so words in
//   flight are dropped, and the offsets return to -164, -41 and 1065.
`default_nettype none

module accel_tilt_roll_pitch_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input channel
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [atrp_pkg::AXIS_W-1:0]       in_accel_x,
  input  logic signed [atrp_pkg::AXIS_W-1:0]       in_accel_y,
  input  logic signed [atrp_pkg::AXIS_W-1:0]       in_accel_z,
  // result channel
  output logic                                     out_valid,
  output logic signed [atrp_pkg::ANGLE_W-1:0]      out_roll_angle,
  output logic signed [atrp_pkg::ANGLE_W-1:0]      out_pitch_angle,
  // configuration port
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [atrp_pkg::CFG_ADDR_W-1:0]          paddr,
  input  logic [atrp_pkg::CFG_DATA_W-1:0]          pwdata,
  output logic [atrp_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                     pready
);
  import atrp_pkg::*;

  // calibration offsets
  logic signed [AXIS_W-1:0] ofs_x_r;
  logic signed [AXIS_W-1:0] ofs_y_r;
  logic signed [AXIS_W-1:0] ofs_z_r;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r <= OFFSET_X_RST;
      ofs_y_r <= OFFSET_Y_RST;
      ofs_z_r <= OFFSET_Z_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_OFFSET_X: ofs_x_r <= pwdata[AXIS_W-1:0];
        REG_OFFSET_Y: ofs_y_r <= pwdata[AXIS_W-1:0];
        REG_OFFSET_Z: ofs_z_r <= pwdata[AXIS_W-1:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  // read back, sign extended to the bus
  always_comb begin
    unique case (paddr[3:2])
      REG_OFFSET_X: prdata = CFG_DATA_W'(ofs_x_r);
      REG_OFFSET_Y: prdata = CFG_DATA_W'(ofs_y_r);
      REG_OFFSET_Z: prdata = CFG_DATA_W'(ofs_z_r);
      default:      prdata = '0;
    endcase
  end

  // nothing ever holds off the input: every stage advances each clock
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // stage a: offset sums, 17 bits so they cannot overflow
  logic                    a_v_r;
  logic signed [SUM_W-1:0] a_x_r;
  logic signed [SUM_W-1:0] a_y_r;
  logic signed [SUM_W-1:0] a_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_x_r <= SUM_W'(in_accel_x) + SUM_W'(ofs_x_r);
    a_y_r <= SUM_W'(in_accel_y) + SUM_W'(ofs_y_r);
    a_z_r <= SUM_W'(in_accel_z) + SUM_W'(ofs_z_r);
  end

  // stage b: squares of the magnitudes
  logic [SUM_W-1:0]        mag_x;
  logic [SUM_W-1:0]        mag_y;
  logic [SUM_W-1:0]        mag_z;
  logic [2*SUM_W-1:0]      prod_x;
  logic [2*SUM_W-1:0]      prod_y;
  logic [2*SUM_W-1:0]      prod_z;

  // -65536 maps to 65536 in the unsigned view, which is what we want
  assign mag_x  = a_x_r[SUM_W-1] ? (~a_x_r + SUM_W'(1)) : a_x_r;
  assign mag_y  = a_y_r[SUM_W-1] ? (~a_y_r + SUM_W'(1)) : a_y_r;
  assign mag_z  = a_z_r[SUM_W-1] ? (~a_z_r + SUM_W'(1)) : a_z_r;
  assign prod_x = (2*SUM_W)'(mag_x) * (2*SUM_W)'(mag_x);
  assign prod_y = (2*SUM_W)'(mag_y) * (2*SUM_W)'(mag_y);
  assign prod_z = (2*SUM_W)'(mag_z) * (2*SUM_W)'(mag_z);

  logic                    b_v_r;
  logic [SQ_W-1:0]         b_sqx_r;
  logic [SQ_W-1:0]         b_sqy_r;
  logic [SQ_W-1:0]         b_sqz_r;
  logic signed [SUM_W-1:0] b_x_r;
  logic signed [SUM_W-1:0] b_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_sqx_r <= prod_x[SQ_W-1:0];
    b_sqy_r <= prod_y[SQ_W-1:0];
    b_sqz_r <= prod_z[SQ_W-1:0];
    b_x_r   <= a_x_r;
    b_y_r   <= a_y_r;
  end

  // stage c: radicands for the two angles
  logic                    c_v_r;
  logic [RAD_W-1:0]        c_rad_roll_r;
  logic [RAD_W-1:0]        c_rad_pitch_r;
  logic signed [SUM_W-1:0] c_x_r;
  logic signed [SUM_W-1:0] c_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    c_rad_roll_r  <= {1'b0, b_sqx_r} + {1'b0, b_sqz_r};
    c_rad_pitch_r <= {1'b0, b_sqy_r} + {1'b0, b_sqz_r};
    c_x_r         <= b_x_r;
    c_y_r         <= b_y_r;
  end

  // roll = atan(y / sqrt(x^2 + z^2)), pitch = atan(x / sqrt(y^2 + z^2))
  logic roll_vld;
  logic pitch_vld;

  atrp_tilt #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_v_r),
    .in_rad    (c_rad_roll_r),
    .in_num    (c_y_r),
    .out_valid (roll_vld),
    .out_angle (out_roll_angle)
  );

  atrp_tilt #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_v_r),
    .in_rad    (c_rad_pitch_r),
    .in_num    (c_x_r),
    .out_valid (pitch_vld),
    .out_angle (out_pitch_angle)
  );

  // both lanes run in lock step
  assign out_valid = roll_vld & pitch_vld;

endmodule

`default_nettype wire

[sv/atrp_checker.sv]
`default_nettype none

module atrp_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [atrp_pkg::ANGLE_W-1:0] out_roll_angle,
  input logic signed [atrp_pkg::ANGLE_W-1:0] out_pitch_angle
);
  import atrp_pkg::*;

  localparam int NST     = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  // edges from the accepting edge to the edge that takes the result
  localparam int LATENCY = FRONT_STAGES + ROOT_STEPS + NST + 1;

  // every accepted word yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after accepted word");

  // no result appears without a word accepted at the right time
  a_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching input word");

  // angles stay within plus or minus 90 degrees
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= ANGLE_MAX && out_roll_angle >= ANGLE_MIN &&
                   out_pitch_angle <= ANGLE_MAX && out_pitch_angle >= ANGLE_MIN))
    else $error("angle out of range");

  // reset flushes the pipe
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind accel_tilt_roll_pitch_top atrp_checker #(
  .CORDIC_STEPS (CORDIC_STEPS)
) u_atrp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_roll_angle  (out_roll_angle),
  .out_pitch_angle (out_pitch_angle)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import atrp_pkg::*;

  // cordic depth used by both the block and the angle predictor
  localparam int STEPS       = 16;
  localparam int LATENCY     = 28 + STEPS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ANGLE_LIMIT = 23040;
  localparam int IDLE_PCT    = 36;

  // the one register index past offset_z, writes there are dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // atan(2^-i) in degrees times 2^16, nearest integer
  localparam longint ATAN_DEG16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // how one axis of a random word is chosen
  typedef enum int {AX_ANY, AX_GRAV, AX_NULL, AX_EDGE} axis_kind_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
  } tilt_pair_t;

  // ------------------------------------------------------------------
  // angle predictor and store of expected angle pairs
  // ------------------------------------------------------------------
  class tilt_scoreboard;
    longint     off_x, off_y, off_z;
    tilt_pair_t angle_q[$];
    int         fails;

    function new();
      off_x = -164;
      off_y = -41;
      off_z = 1065;
      fails = 0;
    endfunction

    // register write, only the low 16 bits count
    function void set_offset(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
      longint v;
      v = longint'($signed(data[AXIS_W-1:0]));
      case (idx)
        REG_OFFSET_X: off_x = v;
        REG_OFFSET_Y: off_y = v;
        REG_OFFSET_Z: off_z = v;
        default: ;
      endcase
    endfunction

    // floor square root, one result bit per pass
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, probe;
      r = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= r + probe) begin
          v -= r + probe;
          r = (r >> 1) + probe;
        end else begin
          r >>= 1;
        end
        probe >>= 2;
      end
      return r;
    endfunction

    // atan(n / sqrt(a^2 + b^2)) in degrees times 256
    function logic signed [ANGLE_W-1:0] tilt_angle(longint n, longint a, longint b);
      longint unsigned ma, mb, d;
      longint cx, cy, sx, sy, acc, r;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      d = root_floor((ma * ma + mb * mb) << 16);
      if (d == 0) begin
        if (n > 0) return ANGLE_W'(ANGLE_LIMIT);
        if (n < 0) return ANGLE_W'(-ANGLE_LIMIT);
        return '0;
      end
      cx = longint'(d);
      cy = n * 256;
      acc = 0;
      for (int i = 0; i < STEPS && i < 24; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cy >= 0) begin
          cx = cx + sy;
          cy = cy - sx;
          acc += ATAN_DEG16[i];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          acc -= ATAN_DEG16[i];
        end
      end
      r = (acc + 128) >>> 8;
      if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
      if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
      return r[ANGLE_W-1:0];
    endfunction

    // accepted sample: work out the angle pair it must give
    function void note_sample(logic signed [AXIS_W-1:0] ax, ay, az);
      longint x, y, z;
      tilt_pair_t p;
      x = longint'(ax) + off_x;
      y = longint'(ay) + off_y;
      z = longint'(az) + off_z;
      p.roll  = tilt_angle(y, x, z);
      p.pitch = tilt_angle(x, y, z);
      angle_q.push_back(p);
    endfunction

    // result word: compare with the oldest expected pair
    function void check_angles(logic signed [ANGLE_W-1:0] roll, pitch);
      tilt_pair_t p;
      if (angle_q.size() == 0) begin
        $display("%0t: result with no sample pending: roll %0d pitch %0d",
                 $time, roll, pitch);
        fails++;
        return;
      end
      p = angle_q.pop_front();
      if (roll !== p.roll) begin
        $display("%0t: roll mismatch: expected %0d actual %0d", $time, p.roll, roll);
        fails++;
      end
      if (pitch !== p.pitch) begin
        $display("%0t: pitch mismatch: expected %0d actual %0d", $time, p.pitch, pitch);
        fails++;
      end
    endfunction

    function int pending();
      return angle_q.size();
    endfunction
  endclass

  // ------------------------------------------------------------------
  // block under test
  // ------------------------------------------------------------------
  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [AXIS_W-1:0]     in_accel_x, in_accel_y, in_accel_z;
  logic                         out_valid;
  logic signed [ANGLE_W-1:0]    out_roll_angle, out_pitch_angle;
  logic                         psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0]        paddr;
  logic [CFG_DATA_W-1:0]        pwdata;
  logic [CFG_DATA_W-1:0]        prdata;
  logic                         pready;

  accel_tilt_roll_pitch_top #(.CORDIC_STEPS(STEPS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .out_valid      (out_valid),
    .out_roll_angle (out_roll_angle),
    .out_pitch_angle(out_pitch_angle),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  tilt_scoreboard sb;
  bit             idle_on;
  int             cycle_count;

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // every result word is taken in the cycle it is shown
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_angles(out_roll_angle, out_pitch_angle);
  end

  // hang guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("accel_tilt_roll_pitch_top verification failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // drivers, all entered and left at a falling edge
  // ------------------------------------------------------------------

  // one sample word, with random idle cycles ahead of it
  task automatic send_sample(input logic [AXIS_W-1:0] ax, ay, az);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start = 1'b0;
        // junk on the data lines while start is low
        in_accel_x = AXIS_W'($urandom);
        in_accel_y = AXIS_W'($urandom);
        in_accel_z = AXIS_W'($urandom);
        @(negedge clk);
      end
    end
    start = 1'b1;
    in_accel_x = ax;
    in_accel_y = ay;
    in_accel_z = az;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_sample(ax, ay, az);
    @(negedge clk);
  endtask

  // sender holds off until every expected word has come back
  task automatic settle();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_offset(idx, data);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // all three offsets, junk in the unused upper bits
  task automatic cfg_offsets(input logic [AXIS_W-1:0] ox, oy, oz);
    cfg_write(REG_OFFSET_X, {16'($urandom), ox});
    cfg_write(REG_OFFSET_Y, {16'($urandom), oy});
    cfg_write(REG_OFFSET_Z, {16'($urandom), oz});
  endtask

  // full-scale corners of the input range
  task automatic send_corners();
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
  endtask

  // directed words under the reset offsets (-164, -41, 1065)
  task automatic send_directed();
    // all sums zero: both angles zero
    send_sample(16'sd164, 16'sd41, -16'sd1065);
    // x and z sums zero: roll at the rail either way, pitch zero
    send_sample(16'sd164, 16'sd1041, -16'sd1065);
    send_sample(16'sd164, -16'sd959, -16'sd1065);
    // y and z sums zero: pitch at the rail either way
    send_sample(16'sd1164, 16'sd41, -16'sd1065);
    send_sample(-16'sd836, 16'sd41, -16'sd1065);
    // flat, 1 g on z
    send_sample(16'sd164, 16'sd41, 16'sd3031);
    // 45 degrees roll, then 45 degrees pitch
    send_sample(16'sd4260, 16'sd4137, -16'sd1065);
    send_sample(16'sd3060, 16'sd41, 16'sd1831);
    // single axis at either rail
    send_sample(16'sd32767, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd32767, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    send_sample(-16'sd32768, 16'sd0, 16'sd0);
    send_sample(16'sd0, -16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    send_corners();
  endtask

  // one axis value of a given kind, off is that axis's offset
  function automatic logic [AXIS_W-1:0] pick_axis(axis_kind_t kind, longint off);
    int v;
    case (kind)
      AX_ANY:  v = $urandom;
      AX_GRAV: v = int'($urandom_range(16384)) - 8192;
      AX_NULL: begin
        // mostly an exact cancel of the offset, sometimes one count off
        v = int'(-off);
        if ($urandom_range(2) == 0) v += int'($urandom_range(2)) - 1;
      end
      default: begin
        case ($urandom_range(4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v[AXIS_W-1:0];
  endfunction

  // random words in a mix of shapes
  task automatic send_random(input int count);
    axis_kind_t kx, ky, kz;
    int shape, free_axis;
    for (int n = 0; n < count; n++) begin
      shape = $urandom_range(99);
      if (shape < 35) begin
        kx = AX_ANY; ky = AX_ANY; kz = AX_ANY;
      end else if (shape < 65) begin
        // gravity-sized readings
        kx = AX_GRAV; ky = AX_GRAV; kz = AX_GRAV;
      end else if (shape < 85) begin
        // two sums near zero: zero denominator and zero numerator cases
        free_axis = $urandom_range(2);
        kx = (free_axis == 0) ? AX_GRAV : AX_NULL;
        ky = (free_axis == 1) ? AX_GRAV : AX_NULL;
        kz = (free_axis == 2) ? AX_ANY : AX_NULL;
      end else begin
        kx = axis_kind_t'($urandom_range(3));
        ky = axis_kind_t'($urandom_range(3));
        kz = axis_kind_t'($urandom_range(3));
      end
      send_sample(pick_axis(kx, sb.off_x), pick_axis(ky, sb.off_y),
                  pick_axis(kz, sb.off_z));
    end
  endtask

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------
  initial begin
    sb = new();
    idle_on = 1'b1;
    cycle_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset offsets
    send_directed();
    send_random(120);

    // largest offsets: sums reach +65534
    settle();
    cfg_offsets(16'sd32767, 16'sd32767, 16'sd32767);
    send_corners();
    send_random(120);

    // smallest offsets: sums reach -65536; back-to-back words, no idling
    settle();
    idle_on = 1'b0;
    cfg_offsets(-16'sd32768, -16'sd32768, -16'sd32768);
    send_corners();
    send_random(120);
    idle_on = 1'b1;

    // zero offsets, then a write past offset_z that must change nothing
    settle();
    cfg_offsets(16'sd0, 16'sd0, 16'sd0);
    cfg_write(REG_UNUSED, $urandom);
    send_random(130);

    // full-range random offsets
    settle();
    cfg_offsets(16'($urandom), 16'($urandom), 16'($urandom));
    send_random(130);

    // calibration-sized random offsets
    settle();
    cfg_offsets(16'(int'($urandom_range(4000)) - 2000),
                16'(int'($urandom_range(4000)) - 2000),
                16'(int'($urandom_range(4000)) - 2000));
    send_random(130);

    // drain, then watch a while for stray result words
    settle();
    repeat (LATENCY + 16) @(negedge clk);

    if (sb.fails == 0 && sb.pending() == 0)
      $display("accel_tilt_roll_pitch_top verification clean");
    else
      $display("accel_tilt_roll_pitch_top verification failed");
    $finish;
  end

endmodule

[files.f]
sv/atrp_pkg.sv
sv/atrp_tilt.sv
sv/accel_tilt_roll_pitch_top.sv
sv/atrp_checker.sv
tb/tb.sv
